/* design/mkte_pkg.sv */
// Shared types, codes and keypad tables for the multi-tap keypad text entry core.
// No dependencies; imported by mkte_edit_ctrl and the top level of the core.
package mkte_pkg;

    // Defaults for the top-level parameter and the window register
    localparam int          TEXT_MAX_DEF  = 16;
    localparam logic [15:0] WINDOW_RESET  = 16'd150;

    // Item kinds (s_tuser)
    localparam logic [2:0] FUNC_KEY    = 3'd0;
    localparam logic [2:0] FUNC_TICK   = 3'd1;
    localparam logic [2:0] FUNC_DELETE = 3'd2;
    localparam logic [2:0] FUNC_CLEAR  = 3'd3;
    localparam logic [2:0] FUNC_READ   = 3'd4;

    // Special keys
    localparam logic [4:0] KEY_SPACE  = 5'd0;
    localparam logic [4:0] KEY_COMMIT = 5'd1;
    localparam logic [4:0] KEY_LAST   = 5'd9;
    localparam logic [3:0] KEY_PQRS   = 4'd7;
    localparam logic [3:0] KEY_WXYZ   = 4'd9;

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Result fields of one item, except the character read from the store
    typedef struct packed {
        logic       accepted;
        logic [4:0] text_length;
        logic       pending_active;
        logic       wrote_char;
        logic [7:0] written_char;
        logic [3:0] written_position;
        logic       read_hit;        // read in range, store data is valid
    } mkte_result_t;

    // First letter of each letter key; letters of a set are consecutive
    function automatic logic [7:0] key_letter(input logic [3:0] key, input logic [1:0] idx);
        logic [7:0] base;
        unique case (key)
            4'd2:    base = "A";
            4'd3:    base = "D";
            4'd4:    base = "G";
            4'd5:    base = "J";
            4'd6:    base = "M";
            4'd7:    base = "P";
            4'd8:    base = "T";
            4'd9:    base = "W";
            default: base = 8'd0;
        endcase
        return base + {6'd0, idx};
    endfunction

    // Highest letter index of a key's set
    function automatic logic [1:0] key_last_index(input logic [3:0] key);
        return (key == KEY_PQRS || key == KEY_WXYZ) ? 2'd3 : 2'd2;
    endfunction

endpackage

/* design/mkte_text_ram.sv */
// Text store of the keypad core: one write port, one read port, registered read data.
// Depends on nothing; instantiated by multitap_keypad_text_entry_core.
module mkte_text_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read, so a stalled result keeps it
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/mkte_edit_ctrl.sv */
// Edit state of the keypad core: length, open key, letter index, window counter,
// window register. Computes one item's result and the store access. Uses mkte_pkg.
module mkte_edit_ctrl
    import mkte_pkg::*;
#(
    parameter int TEXT_MAX = TEXT_MAX_DEF,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write,
    input  logic [15:0]   cfg_data,
    input  logic          in_accept,
    input  logic [2:0]    func,
    input  logic [4:0]    key_code,
    input  logic [3:0]    read_index,
    output mkte_result_t  result,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr
);

    logic [CW-1:0] count_reg,  count_next;
    logic [3:0]    open_reg,   open_next;
    logic [1:0]    letter_reg, letter_next;
    logic [15:0]   window_reg, window_next;
    logic [15:0]   ticks_reg;

    logic          full;
    logic          hit;
    logic          write;
    logic [7:0]    wchar;
    logic [CW-1:0] wpos;

    assign full = (count_reg == CW'(TEXT_MAX));
    assign hit  = (9'(read_index) < 9'(count_reg));

    always_comb
    begin
        count_next  = count_reg;
        open_next   = open_reg;
        letter_next = letter_reg;
        window_next = window_reg;
        write       = 1'b0;
        wchar       = 8'd0;
        wpos        = '0;
        result      = '0;
        result.accepted = 1'b1;

        unique case (func)
            FUNC_KEY:
            begin
                priority if (key_code > KEY_LAST)
                begin
                    result.accepted = 1'b0;
                end
                else if (key_code <= KEY_COMMIT)
                begin
                    open_next = 4'd0;
                    if (key_code == KEY_SPACE && !full)
                    begin
                        write      = 1'b1;
                        wchar      = CHAR_SPACE;
                        wpos       = count_reg;
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (5'(open_reg) == key_code && count_reg != '0)
                begin
                    // repeat press: cycle the last letter in place
                    letter_next = (letter_reg == key_last_index(key_code[3:0]))
                                  ? 2'd0 : letter_reg + 2'd1;
                    write       = 1'b1;
                    wchar       = key_letter(key_code[3:0], letter_next);
                    wpos        = count_reg - 1'b1;
                    window_next = ticks_reg;
                end
                else if (full)
                begin
                    open_next = 4'd0;
                end
                else
                begin
                    open_next   = key_code[3:0];
                    letter_next = 2'd0;
                    write       = 1'b1;
                    wchar       = key_letter(key_code[3:0], 2'd0);
                    wpos        = count_reg;
                    count_next  = count_reg + 1'b1;
                    window_next = ticks_reg;
                end
            end
            FUNC_TICK:
            begin
                if (window_reg != 16'd0)
                begin
                    window_next = window_reg - 16'd1;
                    if (window_reg == 16'd1)
                    begin
                        open_next = 4'd0;
                    end
                end
            end
            FUNC_DELETE:
            begin
                open_next   = 4'd0;
                window_next = 16'd0;
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            FUNC_CLEAR:
            begin
                count_next  = '0;
                open_next   = 4'd0;
                letter_next = 2'd0;
                window_next = 16'd0;
            end
            FUNC_READ:
            begin
                result.read_hit = hit;
            end
            default:
            begin
            end
        endcase

        result.text_length      = 5'(count_next);
        result.pending_active   = (open_next != 4'd0);
        result.wrote_char       = write;
        result.written_char     = wchar;
        result.written_position = 4'(wpos);
    end

    assign wr_en   = in_accept && write;
    assign wr_addr = AW'(wpos);
    assign wr_data = wchar;
    assign rd_en   = in_accept && result.read_hit;
    assign rd_addr = AW'(read_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            open_reg   <= 4'd0;
            letter_reg <= 2'd0;
            window_reg <= 16'd0;
        end
        else if (in_accept)
        begin
            count_reg  <= count_next;
            open_reg   <= open_next;
            letter_reg <= letter_next;
            window_reg <= window_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            ticks_reg <= cfg_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= TEXT_MAX)
        else $error("text length beyond capacity");

    a_open_needs_text: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg != 4'd0 |-> count_reg != '0)
        else $error("open key with empty buffer");

    a_letter_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg != 4'd0 |-> letter_reg <= key_last_index(open_reg))
        else $error("letter index outside the open key's set");

endmodule

/* design/multitap_keypad_text_entry_core.sv */
// Top level of the multi-tap keypad text entry core.
// Uses mkte_pkg, mkte_edit_ctrl and mkte_text_ram.
//
// Usage:
//   s_* carries one editing item per transfer: the kind in s_tuser (key press,
//   tick, delete, clear, read), key code and read index in s_tdata. Each item
//   produces exactly one result transfer on m_*: accept flag, text length,
//   pending flag, written character and position, and the character read.
//   cfg_* writes the window length in ticks; cfg_ready is always high. Write it
//   only while no item is in flight.
//   A result is registered at the edge that accepts its item. Throughput is
//   one item per cycle while m_tready is high. The edit registers update at the
//   accept edge and the store write lands there too, so the next item already
//   sees it; the store read port is registered together with the result.
//   While m_tready is low the result register holds and s_tready drops once
//   the register is full; s_tready = !m_tvalid || m_tready.
//   Reset clears length, open key, letter index and window counter and sets
//   the window to 150 ticks. The store itself is not cleared: reads at or
//   beyond the current length never touch it and answer 0.
module multitap_keypad_text_entry_core
    import mkte_pkg::*;
#(
    parameter int TEXT_MAX = TEXT_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [4:0] key_code, [8:5] read_index, rest zero
    input  logic [2:0]  s_tuser,   // [2:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] accepted, [5:1] text_length, [6] pending_active,
                                   // [7] wrote_char, [15:8] written_char,
                                   // [19:16] written_position, [27:20] read_char
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int AW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
    localparam int CW = $clog2(TEXT_MAX + 1);

    logic          in_accept;
    mkte_result_t  result;
    mkte_result_t  res_reg;
    logic          m_tvalid_reg, m_tvalid_next;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [7:0]    read_char;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    mkte_edit_ctrl #(
        .TEXT_MAX (TEXT_MAX),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .in_accept  (in_accept),
        .func       (s_tuser),
        .key_code   (s_tdata[4:0]),
        .read_index (s_tdata[8:5]),
        .result     (result),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr)
    );

    // Reads and writes come from different items, and a write commits at its
    // accept edge, so a read in the next cycle already sees it.
    mkte_text_ram #(
        .DEPTH (TEXT_MAX),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register: loads on accept, holds while the receiver stalls
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (in_accept)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_reg <= result;
        end
    end

    // out-of-range reads answer 0; store data only counts on a hit
    assign read_char = res_reg.read_hit ? rd_data : 8'd0;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, read_char, res_reg.written_position, res_reg.written_char,
                       res_reg.wrote_char, res_reg.pending_active, res_reg.text_length,
                       res_reg.accepted};

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> m_tvalid_reg)
        else $error("accepted item produced no result");

    a_read_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("store read and write from the same item");

    a_no_access_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |-> !rd_en && !wr_en)
        else $error("store access without an accepted item");

endmodule
